### src/bcmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcmp_pkg
// Shared types and constants of the braking curve motion profiler.
// ----------------------------------------------------------------------------
package bcmp_pkg;

	localparam int unsigned FRAC_BITS_DEF = 16;
	localparam int unsigned MAX_STEPS_DEF = 2000;

	localparam int unsigned SPD_W  = 20;
	localparam int unsigned GAIN_W = 21;
	localparam int unsigned LERR_W = 27;
	localparam int unsigned AERR_W = 19;
	localparam int unsigned TICK_W = 12;
	localparam int unsigned STEP_W = 11;
	localparam int unsigned CFG_IDX_W = 3;

	// Working width of the step datapath: error up to 27 bits.
	localparam int unsigned ERR_W = 27;
	// Square root radicand: 2 * accel * error fits in 48 bits, root in 24.
	localparam int unsigned RAD_W = 48;
	localparam int unsigned ROOT_W = 24;
	// Product of gain and error.
	localparam int unsigned PROD_W = 48;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_LIN  = 3'd0,
		CFG_LIN_ACC  = 3'd1,
		CFG_MAX_ANG  = 3'd2,
		CFG_ANG_ACC  = 3'd3,
		CFG_LIN_GAIN = 3'd4,
		CFG_ANG_GAIN = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_ROTATE = 2'd1,
		PH_LINEAR = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [LERR_W-1:0]  distance;
		logic signed [19:0] yaw_offset;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        phase;
		logic [SPD_W-1:0]  lin_velocity;
		logic [LERR_W-1:0] linear_error;
		logic [SPD_W-1:0]  angular_speed;
		logic [AERR_W-1:0] angular_error;
		logic [TICK_W-1:0] elapsed_ticks;
		logic              last;
	} out_item_t;

	// Limits, current speed and error handed to the step unit for the active phase.
	typedef struct packed {
		logic [SPD_W-1:0]  vmax;
		logic [SPD_W-1:0]  acc;
		logic [GAIN_W-1:0] kp;
		logic [SPD_W-1:0]  speed;
		logic [ERR_W-1:0]  err;
	} step_req_t;

	typedef struct packed {
		logic [SPD_W-1:0] speed;
		logic [ERR_W-1:0] err;
	} step_rsp_t;

endpackage

### src/bcmp_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcmp_mul
// Bit-serial shift and add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module bcmp_mul #(
	parameter int unsigned A_W = 27,
	parameter int unsigned B_W = 22,
	parameter int unsigned P_W = 49
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [A_W-1:0] a,
	input  logic [B_W-1:0] b,
	output logic           done,
	output logic [P_W-1:0] prod
);
	localparam int unsigned CNT_W = $clog2(B_W + 1);

	logic [P_W-1:0]   acc_q;
	logic [P_W-1:0]   mcand_q;
	logic [B_W-1:0]   mplier_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(B_W);
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= P_W'(a);
			mplier_q <= b;
		end else if (busy_q) begin
			if (mplier_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign prod = acc_q;
endmodule

### src/bcmp_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcmp_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module bcmp_sqrt #(
	parameter int unsigned R_W = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [R_W-1:0]   rad,
	output logic             done,
	output logic [R_W/2-1:0] root
);
	localparam int unsigned Q_W = R_W / 2;
	localparam int unsigned CNT_W = $clog2(Q_W + 1);

	logic [R_W-1:0]   rad_q;
	logic [Q_W+1:0]   rem_q;
	logic [Q_W-1:0]   root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [Q_W+1:0]   trial;
	logic [Q_W+1:0]   trial_sub;

	always_comb begin
		trial     = {rem_q[Q_W-1:0], rad_q[R_W-1 -: 2]};
		trial_sub = {root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(Q_W);
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (trial >= trial_sub) begin
				rem_q  <= trial - trial_sub;
				root_q <= {root_q[Q_W-2:0], 1'b1};
			end else begin
				rem_q  <= trial;
				root_q <= {root_q[Q_W-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
endmodule

### src/bcmp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcmp_step
// One profile step: braking root, proportional target, ramp, cap and update.
// ----------------------------------------------------------------------------
module bcmp_step #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  bcmp_pkg::step_req_t req,
	output logic                done,
	output bcmp_pkg::step_rsp_t rsp
);
	import bcmp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_LOAD, S_MUL, S_ROOT, S_RAMP, S_DIV, S_OUT
	} st_t;

	localparam int unsigned MB_W = GAIN_W + 1;
	localparam int unsigned MP_W = ERR_W + MB_W;
	// Division by 20 is a division by 4 followed by a multiply with
	// ceil(2^18 / 5) and a right shift, exact for every 20-bit dividend.
	localparam int unsigned DIV5_SH = 18;
	localparam logic [16:0] DIV5_MUL = 17'd52429;
	localparam int unsigned QP_W = SPD_W - 2 + 17;

	st_t               st_q;
	step_req_t         req_q;
	logic              mul_start, mul_done, sq_start, sq_done;
	logic [MB_W-1:0]   mul_b;
	logic [MP_W-1:0]   mul_p;
	logic [ROOT_W-1:0] root;
	logic [MP_W-1:0]   prop_q;
	logic              mul_brake_q;
	logic [SPD_W-1:0]  spd_q;
	logic [SPD_W-1:0]  delta_q;
	logic [ERR_W+4:0]  cap;
	logic [ROOT_W-1:0] brake;
	logic [MP_W-1:0]   prop_sh;
	logic [ROOT_W-1:0] target;
	logic [QP_W-1:0]   delta_prod;
	logic [QP_W-1:0]   dec_prod;
	logic [SPD_W-1:0]  delta;
	logic [SPD_W:0]    s_new;
	logic [SPD_W-1:0]  dec;

	// The multiplier serves twice: first kp*e, then 2*acc*e.
	assign mul_b = mul_brake_q ? {1'b0, req_q.acc, 1'b0} : MB_W'(req_q.kp);

	bcmp_mul #(.A_W(ERR_W), .B_W(MB_W), .P_W(MP_W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(req_q.err),
		.b(mul_b), .done(mul_done), .prod(mul_p)
	);

	bcmp_sqrt #(.R_W(RAD_W)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .rad(mul_p[RAD_W-1:0]),
		.done(sq_done), .root(root)
	);

	always_comb begin
		if (req_q.err == '0 || req_q.vmax == '0 || req_q.acc == '0)
			brake = '0;
		else if (root > ROOT_W'(req_q.vmax))
			brake = ROOT_W'(req_q.vmax);
		else
			brake = root;
		prop_sh = prop_q >> FRAC_BITS;
		if (prop_sh < MP_W'(brake))
			target = ROOT_W'(prop_sh);
		else
			target = brake;
		delta_prod = QP_W'(req_q.acc[SPD_W-1:2]) * QP_W'(DIV5_MUL);
		delta = SPD_W'(delta_prod >> DIV5_SH);
		// Target never exceeds vmax, so it fits the speed width.
		if (target[SPD_W-1:0] > req_q.speed) begin
			if (target[SPD_W-1:0] - req_q.speed > delta_q)
				s_new = {1'b0, req_q.speed} + {1'b0, delta_q};
			else
				s_new = {1'b0, target[SPD_W-1:0]};
		end else begin
			if (req_q.speed - target[SPD_W-1:0] > delta_q)
				s_new = {1'b0, req_q.speed - delta_q};
			else
				s_new = {1'b0, target[SPD_W-1:0]};
		end
		cap = (ERR_W+5)'(req_q.err) * (ERR_W+5)'(20);
		dec_prod = QP_W'(spd_q[SPD_W-1:2]) * QP_W'(DIV5_MUL);
		dec = SPD_W'(dec_prod >> DIV5_SH);
	end

	assign mul_start = (st_q == S_LOAD);
	assign sq_start  = (st_q == S_MUL && mul_done && mul_brake_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			done        <= 1'b0;
			mul_brake_q <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				S_IDLE: if (start) begin
					st_q        <= S_LOAD;
					mul_brake_q <= 1'b0;
				end
				S_LOAD: st_q <= S_MUL;
				S_MUL: if (mul_done) begin
					if (mul_brake_q)
						st_q <= S_ROOT;
					else begin
						mul_brake_q <= 1'b1;
						st_q        <= S_LOAD;
					end
				end
				S_ROOT: if (sq_done) st_q <= S_RAMP;
				S_RAMP: st_q <= S_DIV;
				S_DIV:  st_q <= S_OUT;
				S_OUT: begin
					st_q <= S_IDLE;
					done <= 1'b1;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && start)
			req_q <= req;
		if (st_q == S_LOAD)
			delta_q <= delta;
		if (st_q == S_MUL && mul_done && !mul_brake_q)
			prop_q <= mul_p;
		if (st_q == S_RAMP)
			spd_q <= ((ERR_W+5)'(s_new) > cap) ? SPD_W'(cap) : s_new[SPD_W-1:0];
		if (st_q == S_DIV) begin
			rsp.speed <= spd_q;
			rsp.err   <= (ERR_W'(dec) >= req_q.err) ? '0 : req_q.err - ERR_W'(dec);
		end
	end

	// The proportional product is ready only after the first multiply.
	assert property (@(posedge clk) disable iff (!arst_n)
		sq_start |-> !mul_start)
		else $error("sqrt and multiplier started together");
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(st_q) == S_OUT)
		else $error("step done outside output state");
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> st_q == S_MUL)
		else $error("multiplier finished in wrong state");
endmodule

### src/braking_curve_motion_profiler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// braking_curve_motion_profiler_top
// Two-phase rotate-then-drive speed profiler with a braking-curve target.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_stall/in_data) carries one transaction
// per command. A start transaction loads the distance and the yaw error; its
// result is offered on the cycle after acceptance.
// A tick transaction advances the active phase by one 0.05 s step and yields
// one result transaction. It takes two passes of the bit-serial multiplier,
// the bit-serial square root, and the operand loading, ramp, update and
// handoff steps before the result is offered. Ticks while idle or finished
// answer like a start, in the cycle after acceptance.
// One command is in work at a time; in_stall is high while a command is
// being processed or while its result waits in the output register.
// The out channel (out_valid/out_stall/out_data) holds a result steady while
// out_stall is high; the next command is accepted once the result is taken.
// Configuration writes (cfg_we/cfg_idx/cfg_data) are registered; they must be
// made only while the block is idle, which the block does not enforce. Reset
// clears all profile state to the idle phase, loads default limits and gains.
// ----------------------------------------------------------------------------
module braking_curve_motion_profiler_top #(
	parameter int unsigned MAX_STEPS = bcmp_pkg::MAX_STEPS_DEF,
	parameter int unsigned FRAC_BITS = bcmp_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  bcmp_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output bcmp_pkg::out_item_t                out_data,
	input  logic                               cfg_we,
	input  logic [bcmp_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [bcmp_pkg::GAIN_W-1:0]        cfg_data
);
	import bcmp_pkg::*;

	// Tolerances rounded to nearest at the configured fraction width.
	localparam longint unsigned LIN_TOL_L = ((64'd2 << FRAC_BITS) + 64'd50) / 64'd100;
	localparam longint unsigned ANG_TOL_L =
		((64'd34906585 << FRAC_BITS) + 64'd500000000) / 64'd1000000000;
	localparam logic [LERR_W-1:0] LIN_TOL = LERR_W'(LIN_TOL_L);
	localparam logic [AERR_W-1:0] ANG_TOL = AERR_W'(ANG_TOL_L);
	localparam logic [STEP_W-1:0] STEP_LIM = STEP_W'(MAX_STEPS);

	typedef enum logic [1:0] {T_IDLE, T_STEP, T_WAIT, T_OUT} top_st_t;

	top_st_t           st_q;
	logic [SPD_W-1:0]  max_lin_q, lin_acc_q, max_ang_q, ang_acc_q;
	logic [GAIN_W-1:0] lin_gain_q, ang_gain_q;
	phase_t            phase_q;
	logic [SPD_W-1:0]  lin_spd_q, ang_spd_q;
	logic [LERR_W-1:0] lin_err_q;
	logic [AERR_W-1:0] ang_err_q;
	logic [STEP_W-1:0] steps_q;
	logic [TICK_W-1:0] ticks_q;
	logic              last_q;
	logic              in_acc;
	logic              step_start, step_done;
	step_req_t         req;
	step_rsp_t         rsp;
	logic [STEP_W-1:0] steps_nx;
	logic [19:0]       yaw_neg;
	logic [AERR_W-1:0] yaw_mag;
	phase_t            start_ph;

	assign in_stall = (st_q != T_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign step_start = in_acc && in_data.operation == OP_TICK &&
		(phase_q == PH_ROTATE || phase_q == PH_LINEAR);

	always_comb begin
		req.err = '0;
		if (phase_q == PH_ROTATE) begin
			req.vmax  = max_ang_q;
			req.acc   = ang_acc_q;
			req.kp    = ang_gain_q;
			req.speed = ang_spd_q;
			req.err   = ERR_W'(ang_err_q);
		end else begin
			req.vmax  = max_lin_q;
			req.acc   = lin_acc_q;
			req.kp    = lin_gain_q;
			req.speed = lin_spd_q;
			req.err   = lin_err_q;
		end
		yaw_neg = 20'(-in_data.yaw_offset);
		if (in_data.yaw_offset[19])
			yaw_mag = yaw_neg[19] ? '1 : yaw_neg[AERR_W-1:0];
		else
			yaw_mag = in_data.yaw_offset[AERR_W-1:0];
		if (yaw_mag > ANG_TOL)
			start_ph = PH_ROTATE;
		else if (in_data.distance > LIN_TOL)
			start_ph = PH_LINEAR;
		else
			start_ph = PH_DONE;
		steps_nx = steps_q + STEP_W'(1);
	end

	bcmp_step #(.FRAC_BITS(FRAC_BITS)) u_step (
		.clk(clk), .arst_n(arst_n), .start(step_start), .req(req),
		.done(step_done), .rsp(rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_lin_q  <= SPD_W'(32768);
			lin_acc_q  <= SPD_W'(32768);
			max_ang_q  <= SPD_W'(32768);
			ang_acc_q  <= SPD_W'(32768);
			lin_gain_q <= GAIN_W'(65536);
			ang_gain_q <= GAIN_W'(98304);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_MAX_LIN:  max_lin_q  <= cfg_data[SPD_W-1:0];
				CFG_LIN_ACC:  lin_acc_q  <= cfg_data[SPD_W-1:0];
				CFG_MAX_ANG:  max_ang_q  <= cfg_data[SPD_W-1:0];
				CFG_ANG_ACC:  ang_acc_q  <= cfg_data[SPD_W-1:0];
				CFG_LIN_GAIN: lin_gain_q <= cfg_data;
				CFG_ANG_GAIN: ang_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= T_IDLE;
			phase_q   <= PH_IDLE;
			lin_spd_q <= '0;
			ang_spd_q <= '0;
			lin_err_q <= '0;
			ang_err_q <= '0;
			steps_q   <= '0;
			ticks_q   <= '0;
			last_q    <= 1'b0;
		end else begin
			unique case (st_q)
				T_IDLE: if (in_acc) begin
					last_q <= 1'b0;
					if (in_data.operation == OP_START) begin
						ang_err_q <= yaw_mag;
						lin_err_q <= in_data.distance;
						lin_spd_q <= '0;
						ang_spd_q <= '0;
						steps_q   <= '0;
						ticks_q   <= '0;
						phase_q   <= start_ph;
						last_q    <= (start_ph == PH_DONE);
						st_q      <= T_OUT;
					end else if (step_start) begin
						if (ticks_q != '1)
							ticks_q <= ticks_q + TICK_W'(1);
						steps_q <= steps_nx;
						st_q    <= T_STEP;
					end else begin
						st_q <= T_OUT;
					end
				end
				T_STEP: if (step_done) st_q <= T_WAIT;
				T_WAIT: begin
					st_q <= T_OUT;
					if (phase_q == PH_ROTATE) begin
						ang_err_q <= rsp.err[AERR_W-1:0];
						ang_spd_q <= rsp.speed;
						if (rsp.err[AERR_W-1:0] <= ANG_TOL || steps_q >= STEP_LIM) begin
							ang_spd_q <= '0;
							lin_spd_q <= '0;
							steps_q   <= '0;
							if (lin_err_q > LIN_TOL)
								phase_q <= PH_LINEAR;
							else begin
								phase_q <= PH_DONE;
								last_q  <= 1'b1;
							end
						end
					end else begin
						lin_err_q <= rsp.err;
						lin_spd_q <= rsp.speed;
						if (rsp.err <= LIN_TOL || steps_q >= STEP_LIM) begin
							lin_spd_q <= '0;
							steps_q   <= '0;
							phase_q   <= PH_DONE;
							last_q    <= 1'b1;
						end
					end
				end
				T_OUT: if (!out_stall) st_q <= T_IDLE;
				default: st_q <= T_IDLE;
			endcase
		end
	end

	assign out_valid = (st_q == T_OUT);
	always_comb begin
		out_data.phase         = phase_q;
		out_data.lin_velocity  = lin_spd_q;
		out_data.linear_error  = lin_err_q;
		out_data.angular_speed = ang_spd_q;
		out_data.angular_error = ang_err_q;
		out_data.elapsed_ticks = ticks_q;
		out_data.last          = last_q;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_q |-> phase_q == PH_DONE)
		else $error("last flagged outside finished phase");
	assert property (@(posedge clk) disable iff (!arst_n)
		step_done |-> st_q == T_STEP)
		else $error("step unit finished unexpectedly");
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ROTATE |-> lin_spd_q == '0)
		else $error("linear speed nonzero while rotating");
endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the braking curve motion profiler against a cycle-free model of the
// rotate-then-drive profile. Directed starts and ticks come first. Random
// profiles follow under several limit settings, with random sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
	import bcmp_pkg::*;

	localparam longint unsigned LIN_TOL = 1311;
	localparam longint unsigned ANG_TOL = 2288;
	localparam int unsigned STEP_LIMIT = 2000;
	localparam longint unsigned CYCLE_LIMIT = 20000000;

	// A tolerance of 0.02 m and of 2 degrees, both at 16 fractional bits.

	class profile_scoreboard;
		longint unsigned vmax_lin, acc_lin, vmax_ang, acc_ang, kp_lin, kp_ang;
		phase_t phase;
		longint unsigned lin_spd, lin_err, ang_spd, ang_err, steps, ticks;
		out_item_t pending[$];
		int errors;

		function new();
			vmax_lin = 32768; acc_lin = 32768; vmax_ang = 32768; acc_ang = 32768;
			kp_lin = 65536; kp_ang = 98304;
			phase = PH_IDLE;
			lin_spd = 0; lin_err = 0; ang_spd = 0; ang_err = 0; steps = 0; ticks = 0;
			errors = 0;
		endfunction

		function void set_limit(cfg_idx_t idx, longint unsigned v);
			case (idx)
				CFG_MAX_LIN:  vmax_lin = v & 20'hFFFFF;
				CFG_LIN_ACC:  acc_lin = v & 20'hFFFFF;
				CFG_MAX_ANG:  vmax_ang = v & 20'hFFFFF;
				CFG_ANG_ACC:  acc_ang = v & 20'hFFFFF;
				CFG_LIN_GAIN: kp_lin = v & 21'h1FFFFF;
				CFG_ANG_GAIN: kp_ang = v & 21'h1FFFFF;
				default: ;
			endcase
		endfunction

		function longint unsigned int_root(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		// One 0.05 s step: braking curve, gain and ramp limits, then the
		// distance covered is taken off the error.
		function void step_axis(ref longint unsigned spd, ref longint unsigned err,
				input longint unsigned vmax, input longint unsigned acc,
				input longint unsigned kp);
			longint unsigned brake, prop, tgt, dlt, s;
			s = spd;
			brake = 0;
			if (err != 0 && vmax != 0 && acc != 0) begin
				brake = int_root(2 * acc * err);
				if (brake > vmax)
					brake = vmax;
			end
			prop = (kp * err) >> 16;
			tgt = (brake < prop) ? brake : prop;
			dlt = acc / 20;
			if (tgt > s)
				s = (tgt - s > dlt) ? s + dlt : tgt;
			else
				s = (s - tgt > dlt) ? s - dlt : tgt;
			if (s > err * 20)
				s = err * 20;
			err = (s / 20 >= err) ? 0 : err - s / 20;
			spd = s & 20'hFFFFF;
		endfunction

		function void note_command(in_item_t it);
			out_item_t r;
			logic fin;
			longint unsigned mag;
			fin = 0;
			if (it.operation == OP_START) begin
				mag = (it.yaw_offset < 0) ? longint'(-int'(it.yaw_offset))
					: longint'(it.yaw_offset);
				if (mag > 19'h7FFFF)
					mag = 19'h7FFFF;
				ang_err = mag;
				lin_err = it.distance;
				lin_spd = 0; ang_spd = 0; steps = 0; ticks = 0;
				if (ang_err > ANG_TOL)
					phase = PH_ROTATE;
				else if (lin_err > LIN_TOL)
					phase = PH_LINEAR;
				else begin
					phase = PH_DONE; fin = 1;
				end
			end else if (phase == PH_ROTATE || phase == PH_LINEAR) begin
				if (ticks < 4095)
					ticks++;
				steps = (steps + 1) & 11'h7FF;
				if (phase == PH_ROTATE) begin
					step_axis(ang_spd, ang_err, vmax_ang, acc_ang, kp_ang);
					ang_err &= 19'h7FFFF;
					if (ang_err <= ANG_TOL || steps >= STEP_LIMIT) begin
						ang_spd = 0; steps = 0; lin_spd = 0;
						if (lin_err > LIN_TOL)
							phase = PH_LINEAR;
						else begin
							phase = PH_DONE; fin = 1;
						end
					end
				end else begin
					step_axis(lin_spd, lin_err, vmax_lin, acc_lin, kp_lin);
					lin_err &= 27'h7FFFFFF;
					if (lin_err <= LIN_TOL || steps >= STEP_LIMIT) begin
						lin_spd = 0; steps = 0; phase = PH_DONE; fin = 1;
					end
				end
			end
			r.phase = phase;
			r.lin_velocity = SPD_W'(lin_spd);
			r.linear_error = LERR_W'(lin_err);
			r.angular_speed = SPD_W'(ang_spd);
			r.angular_error = AERR_W'(ang_err);
			r.elapsed_ticks = TICK_W'(ticks);
			r.last = fin;
			pending.push_back(r);
		endfunction

		function void check_result(out_item_t got);
			out_item_t w;
			if (pending.size() == 0) begin
				report("result with nothing expected", 0, 0);
				return;
			end
			w = pending.pop_front();
			if (got.phase != w.phase) report("phase", got.phase, w.phase);
			if (got.lin_velocity != w.lin_velocity)
				report("lin_velocity", got.lin_velocity, w.lin_velocity);
			if (got.linear_error != w.linear_error)
				report("linear_error", got.linear_error, w.linear_error);
			if (got.angular_speed != w.angular_speed)
				report("angular_speed", got.angular_speed, w.angular_speed);
			if (got.angular_error != w.angular_error)
				report("angular_error", got.angular_error, w.angular_error);
			if (got.elapsed_ticks != w.elapsed_ticks)
				report("elapsed_ticks", got.elapsed_ticks, w.elapsed_ticks);
			if (got.last != w.last) report("last", got.last, w.last);
		endfunction

		function void report(string what, longint unsigned got, longint unsigned want);
			errors++;
			$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	out_item_t out_data;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [GAIN_W-1:0] cfg_data = '0;

	profile_scoreboard board = new();
	longint unsigned cycles = 0;
	int stall_mode = 0;
	int burst_left = 0;
	int items_sent = 0;

	always #4 clk = ~clk;

	braking_curve_motion_profiler_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// The cycle counter is the only guard against a hung block.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Output side: each accepted result transaction is checked, and the
	// stall pattern is re-drawn so that it lands on every phase of a tick.
	// Mode 0 never stalls, mode 1 stalls lightly, mode 2 stalls heavily.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(out_data);
		if ($urandom_range(0, 199) == 0)
			stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	// Sends one command transaction, with random gaps between bursts. Valid
	// stays high after acceptance; a gap in a later call or a drain drops it.
	task automatic send_command(in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_command(it);
		items_sent++;
	endtask

	task automatic start_profile(longint unsigned span, int yaw);
		in_item_t it;
		it.operation = OP_START;
		it.distance = LERR_W'(span);
		it.yaw_offset = 20'(yaw);
		send_command(it);
	endtask

	task automatic tick_once();
		in_item_t it;
		it.operation = OP_TICK;
		it.distance = LERR_W'($urandom);
		it.yaw_offset = 20'($urandom);
		send_command(it);
	endtask

	// Lets every expected result drain, plus a margin for a tick in flight.
	task automatic wait_quiet();
		in_valid <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// Holds the write enable high; the caller drops it after its last write.
	task automatic write_limit(cfg_idx_t idx, longint unsigned v);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= GAIN_W'(v);
		@(posedge clk);
		board.set_limit(idx, v);
	endtask

	// Picks a limit setting: all low, all high, or random within range.
	task automatic load_limits(int kind);
		longint unsigned v;
		for (int i = 0; i < 6; i++) begin
			if (kind == 0)
				v = 66;
			else if (kind == 1)
				v = (i >= 4) ? 1310720 : 655360;
			else
				v = (i >= 4) ? $urandom_range(66, 1310720) : $urandom_range(66, 655360);
			write_limit(cfg_idx_t'(i), v);
		end
		cfg_we <= 0;
	endtask

	task automatic run_profile(int max_ticks);
		longint unsigned span;
		int yaw;
		case ($urandom_range(0, 3))
			0: span = $urandom_range(0, 3000);
			1: span = $urandom_range(0, 200000);
			default: span = $urandom & 27'h7FFFFFF;
		endcase
		yaw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5000) : $urandom_range(0, 411775);
		if ($urandom_range(0, 1)) yaw = -yaw;
		if ($urandom_range(0, 30) == 0) yaw = -524288;
		start_profile(span, yaw);
		for (int t = 0; t < max_ticks && board.phase != PH_DONE; t++)
			tick_once();
		tick_once();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part: ticks while idle, tiny and extreme starts, and both
		// yaw signs including the most negative one, which saturates.
		tick_once();
		start_profile(0, 0);
		tick_once();
		start_profile(27'h7FFFFFF, 411775);
		repeat (4) tick_once();
		start_profile(1311, 2288);
		start_profile(1312, 0);
		repeat (3) tick_once();
		start_profile(5000, -411775);
		start_profile(2000, -524288);
		repeat (3) tick_once();
		start_profile(1000, 2289);
		repeat (4) tick_once();
		wait_quiet();

		// Extremes of the limit registers, then a zero speed limit, gain and
		// acceleration, which must not move the profile.
		load_limits(0);
		run_profile(20);
		wait_quiet();
		load_limits(1);
		run_profile(40);
		wait_quiet();
		write_limit(CFG_MAX_ANG, 0);
		write_limit(CFG_LIN_GAIN, 0);
		write_limit(CFG_LIN_ACC, 0);
		cfg_we <= 0;
		start_profile(100000, 100000);
		repeat (5) tick_once();
		start_profile(100000, 0);
		repeat (5) tick_once();
		wait_quiet();

		// Random profiles, each group under its own limits, with a full
		// drain between groups.
		for (int ph = 0; items_sent < 1350; ph++) begin
			load_limits((ph % 5 == 0) ? ph % 2 : 2);
			for (int k = 0; k < 6 && items_sent < 1350; k++)
				run_profile(60);
			wait_quiet();
		end

		wait_quiet();
		if (board.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
